// ===== rtl/rme_pkg.sv =====
// Shared opcodes, status codes and unit interface types for the register machine executor.
package rme_pkg;

  typedef enum logic [4:0] {
    OP_MOVE    = 5'd0,
    OP_LOAD    = 5'd1,
    OP_STORE   = 5'd2,
    OP_COPY    = 5'd3,
    OP_ADD     = 5'd4,
    OP_SUB     = 5'd5,
    OP_MUL     = 5'd6,
    OP_DIV     = 5'd7,
    OP_COMP    = 5'd8,
    OP_JUMP    = 5'd9,
    OP_JZ      = 5'd10,
    OP_JG      = 5'd11,
    OP_JGE     = 5'd12,
    OP_JL      = 5'd13,
    OP_JLE     = 5'd14,
    OP_JE      = 5'd15,
    OP_JD      = 5'd16,
    OP_GETINT  = 5'd17,
    OP_PRINTLN = 5'd18,
    OP_PRINT   = 5'd19,
    OP_RET     = 5'd20,
    OP_PRELOAD = 5'd21
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_INVALID = 3'd1,
    ST_RANGE   = 3'd2,
    ST_DIVZERO = 3'd3,
    ST_HALTED  = 3'd4
  } status_t;

  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [31:0] a;
    logic [31:0] b;
  } md_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } md_rsp_t;

endpackage

// ===== rtl/rme_regfile.sv =====
// Register file: one registered read port, one write port, entries read as zero until written.
module rme_regfile import rme_pkg::*; #(
  parameter int NUM_REGS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [3:0]  raddr,
  output logic [31:0] rdata,
  input  logic        we,
  input  logic [3:0]  waddr,
  input  logic [31:0] wdata
);
  localparam int IW = $clog2(NUM_REGS);

  logic [31:0]         mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (we && (32'(waddr) < NUM_REGS)) begin
      vld[waddr[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we && (32'(waddr) < NUM_REGS)) begin
      mem[waddr[IW-1:0]] <= wdata;
    end
    if ((32'(raddr) < NUM_REGS) && vld[raddr[IW-1:0]]) begin
      rdata <= mem[raddr[IW-1:0]];
    end else begin
      rdata <= '0;
    end
  end

endmodule

// ===== rtl/rme_muldiv.sv =====
// Shared iterative unit: shift-add multiply and restoring signed divide on one adder.
module rme_muldiv import rme_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  md_req_t req,
  output md_rsp_t rsp
);
  typedef enum logic [2:0] {
    U_IDLE = 3'b001,
    U_RUN  = 3'b010,
    U_FIX  = 3'b100
  } ustate_t;

  ustate_t     state;
  logic [5:0]  cnt;
  logic        is_div;
  logic        neg_q;
  logic [31:0] acc;
  logic [31:0] sh;
  logic [31:0] opnd;
  logic [32:0] add_x;
  logic [32:0] add_y;
  logic        add_sub;
  logic [33:0] sum;
  logic [32:0] r2;
  logic [31:0] mag_a;
  logic [31:0] mag_b;
  logic        done;
  logic [31:0] result;

  assign mag_a = req.a[31] ? (~req.a + 32'd1) : req.a;
  assign mag_b = req.b[31] ? (~req.b + 32'd1) : req.b;
  assign r2    = {acc, sh[31]};
  assign rsp   = '{done: done, result: result};

  always_comb begin
    add_x   = {1'b0, acc};
    add_y   = {1'b0, opnd};
    add_sub = 1'b0;
    if (state == U_FIX) begin
      add_x   = '0;
      add_y   = {1'b0, sh};
      add_sub = 1'b1;
    end else if (is_div) begin
      add_x   = r2;
      add_sub = 1'b1;
    end
  end

  assign sum = {1'b0, add_x} + ({1'b0, add_y} ^ {34{add_sub}}) + 34'(add_sub);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        U_IDLE: begin
          if (req.start) begin
            state <= U_RUN;
          end
        end
        U_RUN: begin
          if (cnt == 6'd31) begin
            state <= is_div ? U_FIX : U_IDLE;
            done  <= !is_div;
          end
        end
        U_FIX: begin
          state <= U_IDLE;
          done  <= 1'b1;
        end
        default: state <= U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      U_IDLE: begin
        cnt    <= '0;
        is_div <= req.is_div;
        neg_q  <= req.a[31] ^ req.b[31];
        acc    <= '0;
        sh     <= req.is_div ? mag_a : req.b;
        opnd   <= req.is_div ? mag_b : req.a;
      end
      U_RUN: begin
        cnt <= cnt + 6'd1;
        if (is_div) begin
          // keep the difference when no borrow
          if (!sum[33]) begin
            acc <= sum[31:0];
            sh  <= {sh[30:0], 1'b1};
          end else begin
            acc <= r2[31:0];
            sh  <= {sh[30:0], 1'b0};
          end
        end else begin
          if (sh[0]) begin
            acc <= sum[31:0];
          end
          opnd <= {opnd[30:0], 1'b0};
          sh   <= {1'b0, sh[31:1]};
        end
        if (!is_div && cnt == 6'd31) begin
          result <= sh[0] ? sum[31:0] : acc;
        end
      end
      U_FIX: begin
        result <= neg_q ? sum[31:0] : sh;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/register_machine_executor_top.sv =====
// Top level: instruction sequencer, data memory, compare flags and program counter.
// Each item passes S_RDA, S_RDB and S_EXEC, then S_MEM for a load or S_UNIT for
// mul and div (the 32-step shared multiply/divide unit), and waits in S_DONE on
// out_stall. Throughput: one item at a time; in_stall stays high from acceptance
// until the result is posted.
// Reset (rst, synchronous) clears registers, memory valid bits, flags and the stop
// flag, sets the pc to 1 and program_length to 0.
module register_machine_executor_top import rme_pkg::*; #(
  parameter int NUM_REGS   = 10,
  parameter int MEM_DEPTH  = 128,
  parameter int PROG_DEPTH = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [4:0]         req_type,
  input  logic [3:0]         dest_reg,
  input  logic               src_is_reg,
  input  logic [3:0]         src_reg,
  input  logic signed [31:0] immediate,
  input  logic [7:0]         jump_target,
  input  logic signed [31:0] user_value,
  input  logic [7:0]         preload_address,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         next_pc,
  output logic               print_valid,
  output logic signed [31:0] print_value,
  output logic               print_newline,
  output logic               halted,
  output logic signed [31:0] exit_status,
  output logic [2:0]         status
);
  localparam int AW   = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int PLIM = (PROG_DEPTH > 255) ? 255 : PROG_DEPTH;
  localparam logic signed [31:0] MEMD = MEM_DEPTH;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_RDA  = 7'b0000010,
    S_RDB  = 7'b0000100,
    S_EXEC = 7'b0001000,
    S_MEM  = 7'b0010000,
    S_UNIT = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [7:0]  program_length;
  logic [7:0]  limit;
  logic [8:0]  pc;
  logic        stopped;
  logic [6:0]  flags;

  opcode_t     op;
  logic [3:0]  dst;
  logic        sreg;
  logic [3:0]  srn;
  logic [31:0] imm;
  logic [7:0]  tgt;
  logic [31:0] uval;
  logic [7:0]  paddr;
  logic [31:0] a;
  logic [31:0] rs;
  logic [31:0] b;

  logic [3:0]  rf_raddr;
  logic [31:0] rf_rdata;
  logic        rf_we;
  logic [31:0] rf_wdata;

  logic [31:0]          dmem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] dvld;
  logic [31:0]          dmem_rdata;
  logic                 mem_we;
  logic [AW-1:0]        mem_addr;
  logic [31:0]          mem_wdata;

  md_req_t     md_req;
  md_rsp_t     md_rsp;

  // result of the execute step, held until the commit
  status_t     e_status;
  logic [8:0]  e_npc;
  logic        e_stop;
  logic        e_exec;
  logic        e_pvalid;
  logic        e_pnl;
  logic [31:0] e_xstat;
  logic        flags_we;
  logic [6:0]  flags_new;

  status_t     res_status;
  logic [8:0]  res_npc;
  logic        res_stop;
  logic        res_exec;
  logic        res_pvalid;
  logic        res_pnl;
  logic [31:0] res_pv;
  logic [31:0] res_xstat;

  logic        bad_addr;
  logic        pre_ok;
  logic        take;
  logic        out_free;
  logic [8:0]  c_npc;
  logic        c_stop;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign limit     = (program_length > 8'(PLIM)) ? 8'(PLIM) : program_length;
  assign b         = sreg ? rs : imm;
  assign bad_addr  = ($signed(b) < 32'sd1) || ($signed(b) > MEMD);
  assign pre_ok    = (paddr != 8'd0) && ($signed(32'(paddr)) <= MEMD);
  assign take      = (op == OP_JUMP) || flags[3'(op - OP_JZ)];
  assign out_free  = !out_valid || !out_stall;

  rme_regfile #(.NUM_REGS(NUM_REGS)) u_regfile (
    .clk   (clk),
    .rst   (rst),
    .raddr (rf_raddr),
    .rdata (rf_rdata),
    .we    (rf_we),
    .waddr (dst),
    .wdata (rf_wdata)
  );

  rme_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  assign rf_raddr = (state == S_IDLE) ? dest_reg : srn;

  always_comb begin
    e_status   = ST_OK;
    e_npc      = pc + 9'd1;
    e_stop     = 1'b0;
    e_exec     = 1'b1;
    e_pvalid   = 1'b0;
    e_pnl      = 1'b0;
    e_xstat    = '0;
    flags_we   = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = AW'(b - 32'd1);
    mem_wdata  = a;
    rf_we      = 1'b0;
    rf_wdata   = imm;
    md_req     = '{start: 1'b0, is_div: (op == OP_DIV), a: a, b: b};
    state_next = S_DONE;
    flags_new  = {($signed(a) != $signed(b)), ($signed(a) == $signed(b)),
                  ($signed(a) <= $signed(b)), ($signed(a) <  $signed(b)),
                  ($signed(a) >= $signed(b)), ($signed(a) >  $signed(b)),
                  (a == 32'd0)};
    if (state == S_EXEC) begin
      if (stopped) begin
        e_exec   = 1'b0;
        e_status = ST_HALTED;
        e_npc    = pc;
        e_stop   = 1'b1;
      end else if (op == OP_PRELOAD) begin
        e_exec    = 1'b0;
        e_npc     = pc;
        mem_addr  = AW'(paddr - 8'd1);
        mem_wdata = imm;
        if (pre_ok) begin
          mem_we = 1'b1;
        end else begin
          e_status = ST_RANGE;
        end
      end else if (pc > {1'b0, limit}) begin
        e_exec = 1'b0;
        e_npc  = pc;
        e_stop = 1'b1;
      end else begin
        case (op)
          OP_MOVE: rf_we = 1'b1;
          OP_LOAD, OP_STORE: begin
            if (bad_addr) begin
              e_status = ST_RANGE;
            end else if (op == OP_STORE) begin
              mem_we = 1'b1;
            end else if (!dvld[mem_addr]) begin
              e_status = ST_INVALID;
            end else begin
              state_next = S_MEM;
            end
          end
          OP_COPY: begin
            rf_we    = 1'b1;
            rf_wdata = rs;
          end
          OP_ADD: begin
            rf_we    = 1'b1;
            rf_wdata = a + b;
          end
          OP_SUB: begin
            rf_we    = 1'b1;
            rf_wdata = a - b;
          end
          OP_MUL, OP_DIV: begin
            if (op == OP_DIV && b == 32'd0) begin
              e_status = ST_DIVZERO;
            end else begin
              md_req.start = 1'b1;
              state_next   = S_UNIT;
            end
          end
          OP_COMP: flags_we = 1'b1;
          OP_JUMP, OP_JZ, OP_JG, OP_JGE, OP_JL, OP_JLE, OP_JE, OP_JD: begin
            if (take) begin
              if (tgt == 8'd0) begin
                e_status = ST_RANGE;
              end else begin
                e_npc = {1'b0, tgt};
              end
            end
          end
          OP_GETINT: begin
            rf_we    = 1'b1;
            rf_wdata = uval;
          end
          OP_PRINTLN, OP_PRINT: begin
            e_pvalid = 1'b1;
            e_pnl    = (op == OP_PRINTLN);
          end
          OP_RET: begin
            e_xstat = imm;
            e_npc   = pc;
            e_stop  = 1'b1;
          end
          default: ;
        endcase
      end
    end else if (state == S_MEM) begin
      rf_we    = 1'b1;
      rf_wdata = dmem_rdata;
    end else if (state == S_UNIT) begin
      rf_we    = md_rsp.done;
      rf_wdata = md_rsp.result;
    end
  end

  // commit: a fault holds the pc at the faulting instruction
  always_comb begin
    c_npc  = res_npc;
    c_stop = stopped | res_stop;
    if (res_exec) begin
      if (res_status != ST_OK) begin
        c_npc  = pc;
        c_stop = 1'b1;
      end else if (res_npc > {1'b0, limit}) begin
        c_stop = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_addr] <= mem_wdata;
    end
    dmem_rdata <= dmem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld <= '0;
    end else if (mem_we) begin
      dvld[mem_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      program_length <= '0;
      pc             <= 9'd1;
      stopped        <= 1'b0;
      flags          <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        program_length <= cfg_data;
      end
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (flags_we) begin
        flags <= flags_new;
      end
      unique case (state)
        S_IDLE: if (in_valid) state <= S_RDA;
        S_RDA:  state <= S_RDB;
        S_RDB:  state <= S_EXEC;
        S_EXEC: state <= state_next;
        S_MEM:  state <= S_DONE;
        S_UNIT: if (md_rsp.done) state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            stopped   <= c_stop;
            if (res_exec && res_status == ST_OK) begin
              pc <= res_npc;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && in_valid) begin
      op    <= opcode_t'(req_type);
      dst   <= dest_reg;
      sreg  <= src_is_reg;
      srn   <= src_reg;
      imm   <= immediate;
      tgt   <= jump_target;
      uval  <= user_value;
      paddr <= preload_address;
    end
    if (state == S_RDA) begin
      a <= rf_rdata;
    end
    if (state == S_RDB) begin
      rs <= rf_rdata;
    end
    if (state == S_EXEC) begin
      res_status <= e_status;
      res_npc    <= e_npc;
      res_stop   <= e_stop;
      res_exec   <= e_exec;
      res_pvalid <= e_pvalid;
      res_pnl    <= e_pnl;
      res_pv     <= e_pvalid ? a : 32'd0;
      res_xstat  <= e_xstat;
    end
    if (state == S_DONE && out_free) begin
      next_pc       <= c_npc[7:0];
      print_valid   <= res_pvalid;
      print_value   <= res_pv;
      print_newline <= res_pnl;
      halted        <= c_stop;
      exit_status   <= res_xstat;
      status        <= res_status;
    end
  end

endmodule

// ===== rtl/rme_checker.sv =====
// Port-level checker for the register machine executor, bound to the top level.
module rme_checker import rme_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       halted,
  input logic [2:0] status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the item finished");

  a_halt_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_HALTED |-> halted)
    else $error("already-halted status without halted flag");

  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_INVALID || status == ST_DIVZERO) |-> halted)
    else $error("fault did not stop the machine");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind register_machine_executor_top rme_checker u_rme_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .halted    (halted),
  .status    (status)
);

// ===== tb/rme_result_checker.sv =====
// Result checker: shadow executor of the register machine and comparison of every posted result.
module rme_result_checker import rme_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [4:0]         req_type,
  input  logic [3:0]         dest_reg,
  input  logic               src_is_reg,
  input  logic [3:0]         src_reg,
  input  logic signed [31:0] immediate,
  input  logic [7:0]         jump_target,
  input  logic signed [31:0] user_value,
  input  logic [7:0]         preload_address,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         next_pc,
  input  logic               print_valid,
  input  logic signed [31:0] print_value,
  input  logic               print_newline,
  input  logic               halted,
  input  logic signed [31:0] exit_status,
  input  logic [2:0]         status,
  output int                 fail_count,
  output int                 open_count
);

  typedef struct packed {
    logic [7:0]  npc;
    logic        pvalid;
    logic [31:0] pvalue;
    logic        pnl;
    logic        halt;
    logic [31:0] xstat;
    logic [2:0]  st;
  } exec_result_t;

  logic [31:0] regfile [10];
  logic [31:0] mem_word [128];
  bit          mem_ok [128];
  logic [6:0]  flags;
  logic [31:0] rem_val;
  int          pc;
  bit          stopped;
  int          prog_len;
  exec_result_t expected_results[$];

  function automatic logic [31:0] read_reg(logic [3:0] n);
    return (n < 10) ? regfile[n] : 32'd0;
  endfunction

  task automatic write_reg(logic [3:0] n, logic [31:0] v);
    if (n < 10) regfile[n] = v;
  endtask

  task automatic execute_instruction(output exec_result_t res);
    int          limit;
    int          npc;
    int          ad;
    bit          stop_now;
    bit          take;
    logic [31:0] a, b, ma, mb, q, r;
    logic [63:0] prod;
    logic [2:0]  st;
    limit = (prog_len < 128) ? prog_len : 128;
    npc = pc + 1;
    stop_now = 0;
    st = ST_OK;
    a = read_reg(dest_reg);
    b = src_is_reg ? read_reg(src_reg) : immediate;
    res.pvalid = 0;
    res.pvalue = 0;
    res.pnl = 0;
    res.xstat = 0;
    if (stopped) begin
      st = ST_HALTED;
      npc = pc;
    end else if (req_type == OP_PRELOAD) begin
      npc = pc;
      if (preload_address >= 1 && preload_address <= 128) begin
        mem_word[preload_address - 1] = immediate;
        mem_ok[preload_address - 1] = 1;
      end else begin
        st = ST_RANGE;
      end
    end else if (pc > limit) begin
      npc = pc;
      stop_now = 1;
    end else begin
      case (req_type)
        OP_MOVE: write_reg(dest_reg, immediate);
        OP_LOAD, OP_STORE: begin
          ad = $signed(b);
          if (ad < 1 || ad > 128) st = ST_RANGE;
          else if (req_type == OP_LOAD) begin
            if (mem_ok[ad - 1]) write_reg(dest_reg, mem_word[ad - 1]);
            else st = ST_INVALID;
          end else begin
            mem_word[ad - 1] = a;
            mem_ok[ad - 1] = 1;
          end
        end
        OP_COPY: write_reg(dest_reg, read_reg(src_reg));
        OP_ADD: write_reg(dest_reg, a + b);
        OP_SUB: write_reg(dest_reg, a - b);
        OP_MUL: begin
          prod = {32'd0, a} * {32'd0, b};
          write_reg(dest_reg, prod[31:0]);
        end
        OP_DIV: begin
          if (b == 0) st = ST_DIVZERO;
          else begin
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            q = ma / mb;
            r = ma % mb;
            if (a[31] ^ b[31]) q = -q;
            if (a[31]) r = -r;
            rem_val = r;
            write_reg(dest_reg, q);
          end
        end
        OP_COMP: begin
          flags[0] = ($signed(a) == 0);
          flags[1] = ($signed(a) > $signed(b));
          flags[2] = ($signed(a) >= $signed(b));
          flags[3] = ($signed(a) < $signed(b));
          flags[4] = ($signed(a) <= $signed(b));
          flags[5] = (a == b);
          flags[6] = (a != b);
        end
        OP_JUMP, OP_JZ, OP_JG, OP_JGE, OP_JL, OP_JLE, OP_JE, OP_JD: begin
          take = (req_type == OP_JUMP) ? 1'b1 : flags[req_type - OP_JZ];
          if (take) begin
            if (jump_target == 0) st = ST_RANGE;
            else npc = jump_target;
          end
        end
        OP_GETINT: write_reg(dest_reg, user_value);
        OP_PRINTLN, OP_PRINT: begin
          res.pvalid = 1;
          res.pvalue = a;
          res.pnl = (req_type == OP_PRINTLN);
        end
        OP_RET: begin
          res.xstat = immediate;
          npc = pc;
          stop_now = 1;
        end
        default: ;
      endcase
      if (st != ST_OK) begin
        npc = pc;
        stop_now = 1;
      end else begin
        pc = npc;
        if (npc > limit) stop_now = 1;
      end
    end
    if (stop_now) stopped = 1;
    res.npc = npc[7:0];
    res.halt = stopped;
    res.st = st;
  endtask

  always @(posedge clk) begin
    exec_result_t got, want;
    if (rst) begin
      for (int i = 0; i < 10; i++) regfile[i] = 0;
      for (int i = 0; i < 128; i++) begin
        mem_word[i] = 0;
        mem_ok[i] = 0;
      end
      flags = 0;
      rem_val = 0;
      pc = 1;
      stopped = 0;
      prog_len = 0;
      expected_results.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{next_pc, print_valid, print_value, print_newline, halted, exit_status, status};
        if (expected_results.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result transaction: npc %0d status %0d",
                                        next_pc, status);
        end else begin
          want = expected_results.pop_front();
          if (got != want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) begin
              $display("mismatch exp: npc %0d pv %0b val %h nl %0b halt %0b exit %h st %0d",
                       want.npc, want.pvalid, want.pvalue, want.pnl, want.halt, want.xstat,
                       want.st);
              $display("         got: npc %0d pv %0b val %h nl %0b halt %0b exit %h st %0d",
                       got.npc, got.pvalid, got.pvalue, got.pnl, got.halt, got.xstat, got.st);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) prog_len = cfg_data;
      if (in_valid && !in_stall) begin
        execute_instruction(want);
        expected_results.push_back(want);
      end
    end
    open_count <= expected_results.size();
  end

endmodule

// ===== tb/register_machine_executor_top_test.sv =====
// Testbench top: drives instruction and length transactions into the executor and gives the verdict.
module register_machine_executor_top_test;
  import rme_pkg::*;

  typedef struct {
    logic [4:0]  op;
    logic [3:0]  dst;
    logic        sreg;
    logic [3:0]  srn;
    logic [31:0] imm;
    logic [7:0]  tgt;
    logic [31:0] uval;
    logic [7:0]  paddr;
  } instr_t;

  logic               clk, rst;
  logic               cfg_valid, cfg_ready;
  logic [7:0]         cfg_data;
  logic               in_valid, in_stall;
  logic [4:0]         req_type;
  logic [3:0]         dest_reg, src_reg;
  logic               src_is_reg;
  logic signed [31:0] immediate, user_value;
  logic [7:0]         jump_target, preload_address;
  logic               out_valid, out_stall;
  logic [7:0]         next_pc;
  logic               print_valid, print_newline, halted;
  logic signed [31:0] print_value, exit_status;
  logic [2:0]         status;
  int                 fail_count, open_count;

  // generator bookkeeping: upper bound of the pc, known-valid words, address in r8
  int  pc_hi = 1;
  int  len_eff = 0;
  int  n_sent = 0;
  int  n_lengths = 0;
  int  burst_left = 0;
  bit  mem_ok [1:128];
  logic [31:0] addr_reg = 0;

  register_machine_executor_top uut (.*);

  rme_result_checker chk (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  initial begin
    #40_000_000;
    $display("timeout waiting for the executor");
    $display("[FAIL] regression broken");
    $finish;
  end

  // receiver: random stall pattern, plus one long hold-off after 600 results
  initial begin
    int  n_out, left, mode, hold;
    bit  long_done, stall;
    n_out = 0; left = 0; mode = 0; hold = 0; long_done = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) n_out++;
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(1, 40);
      end
      left--;
      case (mode)
        0: stall = 0;
        1: stall = $urandom_range(0, 1);
        default: stall = 1;
      endcase
      if (!long_done && n_out >= 600) begin
        long_done = 1;
        hold = 500;
      end
      if (hold > 0) begin
        hold--;
        stall = 1;
      end
      out_stall <= stall;
    end
  end

  function automatic instr_t mk(logic [4:0] op, logic [3:0] dst, logic sreg, logic [3:0] srn,
                                logic [31:0] imm, logic [7:0] tgt, logic [31:0] uval,
                                logic [7:0] paddr);
    instr_t it;
    it = '{op, dst, sreg, srn, imm, tgt, uval, paddr};
    return it;
  endfunction

  task automatic send_item(input instr_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_valid        <= 1'b1;
    req_type        <= it.op;
    dest_reg        <= it.dst;
    src_is_reg      <= it.sreg;
    src_reg         <= it.srn;
    immediate       <= it.imm;
    jump_target     <= it.tgt;
    user_value      <= it.uval;
    preload_address <= it.paddr;
    do @(posedge clk); while (in_stall);
    burst_left--;
    n_sent++;
  endtask

  // send an instruction that must not halt; insert a jump back when the pc sits at the end
  task automatic issue(input instr_t it);
    logic [7:0] t;
    if (it.op != OP_PRELOAD && pc_hi >= len_eff) begin
      t = 8'($urandom_range(1, len_eff));
      send_item(mk(OP_JUMP, 4'($urandom), 1'($urandom), 4'($urandom), $urandom, t, $urandom,
                   8'($urandom)));
      pc_hi = t;
    end
    send_item(it);
    case (it.op)
      OP_PRELOAD: if (it.paddr >= 1 && it.paddr <= 128) mem_ok[it.paddr] = 1;
      OP_STORE: mem_ok[it.sreg ? addr_reg[7:0] : it.imm[7:0]] = 1;
      OP_MOVE: if (it.dst == 8) addr_reg = it.imm;
      default: ;
    endcase
    if (it.op == OP_JUMP) pc_hi = it.tgt;
    else if (it.op >= OP_JZ && it.op <= OP_JD) pc_hi = (it.tgt > pc_hi + 1) ? it.tgt : pc_hi + 1;
    else if (it.op != OP_PRELOAD) pc_hi++;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_length(input logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    len_eff = (v < 128) ? v : 128;
    n_lengths++;
  endtask

  task automatic make_random(output instr_t it);
    int  r, tries;
    logic [7:0] a;
    it = mk(5'($urandom), 4'($urandom), 1'($urandom), 4'($urandom), $urandom, 8'($urandom),
            $urandom, 8'($urandom));
    r = $urandom_range(0, 99);
    if (r < 4) it.op = 5'($urandom_range(22, 31));
    else if (r < 10) it.op = OP_PRELOAD;
    else it.op = 5'($urandom_range(0, 19));
    // writes go to r0..r7 or to nonexistent r10..r15; r8 and r9 are reserved
    r = $urandom_range(0, 13);
    if (it.op inside {OP_MOVE, OP_LOAD, OP_COPY, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GETINT})
      it.dst = 4'((r < 8) ? r : r + 2);
    case (it.op)
      OP_MOVE: begin
        r = $urandom_range(0, 19);
        if (r < 2) begin
          it.dst = 8;
          it.imm = $urandom_range(1, 128);
        end else if (r < 3) begin
          it.dst = 9;
          if (it.imm == 0) it.imm = 1;
        end
      end
      OP_LOAD: begin
        if (it.sreg && mem_ok[addr_reg[7:0]]) it.srn = 8;
        else begin
          it.sreg = 0;
          tries = 0;
          a = 8'($urandom_range(1, 128));
          while (!mem_ok[a] && tries < 8) begin
            a = 8'($urandom_range(1, 128));
            tries++;
          end
          if (mem_ok[a]) it.imm = 32'(a);
          else begin
            it.op = OP_PRELOAD;
            it.paddr = a;
          end
        end
      end
      OP_STORE: begin
        if (it.sreg) it.srn = 8;
        else it.imm = $urandom_range(1, 128);
      end
      OP_DIV: begin
        if (it.sreg) it.srn = 9;
        else if (it.imm == 0) it.imm = 1;
      end
      OP_JUMP, OP_JZ, OP_JG, OP_JGE, OP_JL, OP_JLE, OP_JE, OP_JD:
        it.tgt = 8'($urandom_range(1, len_eff));
      OP_PRELOAD:
        if ($urandom_range(0, 9) != 0) it.paddr = 8'($urandom_range(1, 128));
      default: ;
    endcase
  endtask

  task automatic random_phase(input int count);
    instr_t it;
    repeat (count) begin
      make_random(it);
      issue(it);
    end
  endtask

  initial begin
    instr_t it;
    int     k;
    string  fault_name [7];
    fault_name = '{"return", "divide by zero", "store out of range", "load below range",
                   "jump to zero", "pc beyond length", "normal end"};
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_data = 0;
    in_valid = 1'b0; req_type = 0; dest_reg = 0; src_is_reg = 0; src_reg = 0;
    immediate = 0; jump_target = 1; user_value = 0; preload_address = 1;
    for (int i = 1; i <= 128; i++) mem_ok[i] = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // length zero: only preloads, which ignore the pc
    set_length(8'd0);
    issue(mk(OP_PRELOAD, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 8'd1));
    issue(mk(OP_PRELOAD, 0, 0, 0, 32'h1234_5678, 1, 0, 8'd0));
    issue(mk(OP_PRELOAD, 0, 0, 0, 32'h0BAD_0BAD, 1, 0, 8'd255));
    issue(mk(OP_PRELOAD, 0, 0, 0, 32'h8000_0000, 1, 0, 8'd128));
    set_length(8'd128);
    issue(mk(OP_MOVE, 8, 0, 0, 32'd5, 1, 0, 1));
    issue(mk(OP_MOVE, 9, 0, 0, 32'hFFFF_FFFF, 1, 0, 1));
    issue(mk(OP_MOVE, 0, 1, 3, 32'h8000_0000, 1, 0, 1));
    issue(mk(OP_DIV, 0, 1, 9, 32'd0, 1, 0, 1));
    issue(mk(OP_MOVE, 2, 0, 0, -32'sd7, 1, 0, 1));
    issue(mk(OP_DIV, 2, 0, 0, 32'd2, 1, 0, 1));
    issue(mk(OP_MOVE, 1, 0, 0, 32'h7FFF_FFFF, 1, 0, 1));
    issue(mk(OP_ADD, 1, 0, 0, 32'd1, 1, 0, 1));
    issue(mk(OP_MUL, 1, 1, 1, 32'd0, 1, 0, 1));
    issue(mk(OP_SUB, 1, 0, 0, 32'h8000_0001, 1, 0, 1));
    issue(mk(OP_STORE, 1, 1, 8, 32'd0, 1, 0, 1));
    issue(mk(OP_LOAD, 3, 1, 8, 32'd0, 1, 0, 1));
    issue(mk(OP_LOAD, 4, 0, 0, 32'd128, 1, 0, 1));
    issue(mk(OP_COPY, 5, 0, 1, 32'd77, 1, 0, 1));
    issue(mk(OP_MOVE, 12, 0, 0, 32'd3, 1, 0, 1));
    issue(mk(OP_PRINT, 12, 0, 0, 32'd0, 1, 0, 1));
    issue(mk(OP_PRINTLN, 0, 0, 0, 32'd0, 1, 0, 1));
    issue(mk(OP_COMP, 2, 1, 2, 32'd0, 1, 0, 1));
    issue(mk(OP_JE, 0, 0, 0, 32'd0, 8'd40, 0, 1));
    issue(mk(OP_JD, 0, 0, 0, 32'd0, 8'd2, 0, 1));
    issue(mk(OP_GETINT, 6, 0, 0, 32'd0, 1, 32'h8000_0000, 1));
    issue(mk(OP_GETINT, 15, 0, 0, 32'd0, 1, 32'h7FFF_FFFF, 1));
    issue(mk(5'd22, 0, 0, 0, 32'd0, 1, 0, 1));
    issue(mk(5'd31, 15, 1, 15, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF));
    issue(mk(OP_JUMP, 0, 0, 0, 32'd0, 8'd128, 0, 1));

    random_phase(400);
    for (int i = 0; i < 4; i++) begin
      issue(mk(OP_JUMP, 0, 0, 0, 32'd0, 8'd1, 0, 1));
      case (i)
        0: set_length(8'd255);
        1: set_length(8'd3);
        2: set_length(8'd60);
        default: set_length(8'd200);
      endcase
      random_phase((i == 1) ? 200 : 380);
    end

    // stop the run (return, fault or end of program), then items against the stopped machine
    k = $urandom_range(0, 6);
    issue(mk(OP_JUMP, 0, 0, 0, 32'd0, 8'd1, 0, 1));
    case (k)
      0: send_item(mk(OP_RET, 0, 0, 0, $urandom, 1, 0, 1));
      1: send_item(mk(OP_DIV, 0, 0, 0, 32'd0, 1, 0, 1));
      2: send_item(mk(OP_STORE, 0, 0, 0, 32'd129, 1, 0, 1));
      3: send_item(mk(OP_LOAD, 0, 0, 0, -32'sd5, 1, 0, 1));
      4: send_item(mk(OP_JUMP, 0, 0, 0, 32'd0, 8'd0, 0, 1));
      5: begin
        set_length(8'd0);
        send_item(mk(OP_MOVE, 0, 0, 0, 32'd1, 1, 0, 1));
      end
      default: begin
        send_item(mk(OP_JUMP, 0, 0, 0, 32'd0, 8'd128, 0, 1));
        send_item(mk(OP_MOVE, 0, 0, 0, 32'd1, 1, 0, 1));
      end
    endcase
    send_item(mk(OP_PRELOAD, 0, 0, 0, 32'd9, 1, 0, 8'd7));
    send_item(mk(OP_RET, 0, 0, 0, 32'd1, 1, 0, 1));
    send_item(mk(OP_PRINT, 0, 0, 0, 32'd0, 1, 0, 1));

    drain();
    $display("covered %0d instruction transactions under %0d program lengths", n_sent, n_lengths);
    $display("run closed by the %s fault, then items sent to the stopped machine",
             fault_name[k]);
    if (fail_count == 0 && open_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures, %0d results outstanding", fail_count, open_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
